### rtl/ps2kc_pkg.sv
// ps2kc_pkg: types, codes and constants for the dual PS/2 8042-style controller.
// Used by ps2kc_core and ps2_keyboard_controller_8042. No dependencies.
package ps2kc_pkg;

  // Host access or port event selector carried with each item
  typedef enum logic [2:0] {
    SEL_READ_DATA   = 3'd0,
    SEL_READ_STATUS = 3'd1,
    SEL_WRITE_DATA  = 3'd2,
    SEL_WRITE_CMD   = 3'd3,
    SEL_KBD_EVENT   = 3'd4,
    SEL_MOUSE_EVENT = 3'd5
  } sel_t;

  // Port event codes
  typedef enum logic [2:0] {
    EV_SENT     = 3'd0,
    EV_RECEIVED = 3'd1,
    EV_RX_ERROR = 3'd2,
    EV_OVERFLOW = 3'd3,
    EV_NO_ACK   = 3'd4,
    EV_TIMEOUT  = 3'd5
  } event_t;

  // Configuration register indexes
  typedef enum logic {
    REG_KBD_PRESENT   = 1'b0,
    REG_MOUSE_PRESENT = 1'b1
  } cfg_reg_t;

  // Status register bits
  localparam logic [7:0] ST_OBF      = 8'h01;
  localparam logic [7:0] ST_IBF      = 8'h02;
  localparam logic [7:0] ST_SELFTEST = 8'h04;
  localparam logic [7:0] ST_CMD      = 8'h08;
  localparam logic [7:0] ST_AUX_OBF  = 8'h21;
  localparam logic [7:0] ST_GTO      = 8'h40;
  localparam logic [7:0] ST_PERR     = 8'h80;

  // Mode (command) byte bits
  localparam logic [7:0] MODE_DIS_KBD = 8'h10;
  localparam logic [7:0] MODE_MASK    = 8'h37;

  // Controller command codes
  localparam logic [7:0] CC_READ_MODE  = 8'h20;
  localparam logic [7:0] CC_WRITE_MODE = 8'h60;
  localparam logic [7:0] CC_VERSION    = 8'hA1;
  localparam logic [7:0] CC_TEST_AUX   = 8'hA9;
  localparam logic [7:0] CC_SELF_TEST  = 8'hAA;
  localparam logic [7:0] CC_TEST_KBD   = 8'hAB;
  localparam logic [7:0] CC_KBD_OFF    = 8'hAD;
  localparam logic [7:0] CC_KBD_ON     = 8'hAE;
  localparam logic [7:0] CC_WRITE_AOUT = 8'hD3;
  localparam logic [7:0] CC_WRITE_AUX  = 8'hD4;

  // Answer bytes
  localparam logic [7:0] VERSION_BYTE = 8'h00;
  localparam logic [7:0] TEST_PASS    = 8'h00;
  localparam logic [7:0] TEST_FAIL    = 8'h04;
  localparam logic [7:0] SELF_OK      = 8'h55;

  // One input beat
  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] host_byte;
    logic [2:0] event_code;
    logic [7:0] rx_byte;
  } item_t;

  // One result beat
  typedef struct packed {
    logic [7:0] read_value;
    logic       send_valid;
    logic       send_to_mouse;
    logic [7:0] send_byte;
    logic       keyboard_irq_enable;
    logic       mouse_irq_enable;
  } result_t;

endpackage

### rtl/ps2kc_core.sv
// ps2kc_core: controller state (output byte, status, last host byte, mode byte)
// and the single-pass next-state and result logic. Depends on ps2kc_pkg.
module ps2kc_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  ps2kc_pkg::item_t  item,
  input  logic              keyboard_present,
  input  logic              mouse_present,
  output ps2kc_pkg::result_t result
);
  import ps2kc_pkg::*;

  logic [7:0] output_byte, output_byte_next;
  logic [7:0] status_bits, status_bits_next;
  logic [7:0] last_host_byte, last_host_byte_next;
  logic [7:0] mode_byte, mode_byte_next;

  // Work out state updates and the result for the held item
  always_comb begin
    logic [7:0] prior;
    prior               = (status_bits & ST_CMD) != 8'h00 ? last_host_byte : 8'h00;
    output_byte_next    = output_byte;
    status_bits_next    = status_bits;
    last_host_byte_next = last_host_byte;
    mode_byte_next      = mode_byte;
    result              = '0;

    unique case (item.cmd)
      SEL_READ_DATA: begin
        result.read_value = output_byte;
        status_bits_next  = status_bits & ~ST_AUX_OBF;
      end
      SEL_READ_STATUS: begin
        result.read_value = status_bits;
        status_bits_next  = status_bits & ~(ST_GTO | ST_PERR);
      end
      SEL_WRITE_DATA: begin
        last_host_byte_next = item.host_byte;
        status_bits_next    = status_bits & ~ST_CMD;
        // Parameter of a pending command, else pass the byte to a port
        if (prior == CC_WRITE_MODE) begin
          mode_byte_next = item.host_byte & MODE_MASK;
        end else if (prior == CC_WRITE_AOUT) begin
          output_byte_next = item.host_byte;
          status_bits_next = status_bits_next | ST_AUX_OBF;
        end else begin
          result.send_valid    = 1'b1;
          result.send_to_mouse = (prior == CC_WRITE_AUX);
          result.send_byte     = item.host_byte;
          status_bits_next     = status_bits_next | ST_IBF;
        end
      end
      SEL_WRITE_CMD: begin
        last_host_byte_next = item.host_byte;
        status_bits_next    = status_bits | ST_CMD;
        case (item.host_byte)
          CC_READ_MODE: begin
            output_byte_next = mode_byte;
            status_bits_next = status_bits_next | ST_OBF;
          end
          CC_VERSION: begin
            output_byte_next = VERSION_BYTE;
            status_bits_next = status_bits_next | ST_OBF;
          end
          CC_TEST_AUX: begin
            output_byte_next = mouse_present ? TEST_PASS : TEST_FAIL;
            status_bits_next = status_bits_next | ST_OBF;
          end
          CC_SELF_TEST: begin
            output_byte_next = SELF_OK;
            status_bits_next = status_bits_next | ST_OBF | ST_SELFTEST;
          end
          CC_TEST_KBD: begin
            output_byte_next = keyboard_present ? TEST_PASS : TEST_FAIL;
            status_bits_next = status_bits_next | ST_OBF;
          end
          CC_KBD_OFF: mode_byte_next = mode_byte | MODE_DIS_KBD;
          CC_KBD_ON:  mode_byte_next = mode_byte & ~MODE_DIS_KBD;
          default: ;
        endcase
        status_bits_next = status_bits_next & ~ST_IBF;
      end
      SEL_KBD_EVENT: begin
        case (item.event_code)
          EV_SENT: status_bits_next = status_bits & ~ST_IBF;
          EV_RECEIVED: begin
            output_byte_next = item.rx_byte;
            status_bits_next = status_bits | ST_OBF;
          end
          EV_RX_ERROR, EV_OVERFLOW: status_bits_next = status_bits | ST_PERR;
          EV_NO_ACK, EV_TIMEOUT:    status_bits_next = status_bits | ST_GTO;
          default: ;
        endcase
      end
      SEL_MOUSE_EVENT: begin
        // Mouse errors leave status alone
        case (item.event_code)
          EV_SENT: status_bits_next = status_bits & ~ST_IBF;
          EV_RECEIVED: begin
            output_byte_next = item.rx_byte;
            status_bits_next = status_bits | ST_AUX_OBF;
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    result.keyboard_irq_enable = mode_byte_next[0];
    result.mouse_irq_enable    = mode_byte_next[1];
  end

  // Commit control state on each beat
  always_ff @(posedge clk) begin
    if (rst) begin
      status_bits    <= '0;
      last_host_byte <= '0;
      mode_byte      <= '0;
    end else if (fire) begin
      status_bits    <= status_bits_next;
      last_host_byte <= last_host_byte_next;
      mode_byte      <= mode_byte_next;
    end
  end

  // Output byte holds payload only
  always_ff @(posedge clk) begin
    if (fire) begin
      output_byte <= output_byte_next;
    end
  end

  function automatic logic prior_is_write_mode();
    return (status_bits & ST_CMD) != 8'h00 && last_host_byte == CC_WRITE_MODE;
  endfunction

  a_status_read_clears: assert property (@(posedge clk) disable iff (rst)
    fire && item.cmd == SEL_READ_STATUS |=> (status_bits & (ST_GTO | ST_PERR)) == 8'h00)
    else $error("status read left timeout or parity set");

  a_cmd_write_marks: assert property (@(posedge clk) disable iff (rst)
    fire && item.cmd == SEL_WRITE_CMD |=> (status_bits & ST_CMD) != 8'h00
      && (status_bits & ST_IBF) == 8'h00 && last_host_byte == $past(item.host_byte))
    else $error("command write did not update status or last byte");

  a_mode_masked: assert property (@(posedge clk) disable iff (rst)
    fire && item.cmd == SEL_WRITE_DATA && prior_is_write_mode()
    |=> mode_byte == ($past(item.host_byte) & MODE_MASK))
    else $error("mode byte write not masked");

endmodule

### rtl/ps2_keyboard_controller_8042.sv
// Dual PS/2 port controller that presents a PC 8042 keyboard controller to a host.
// A beat is accepted on the item channel whenever item_stall is low; it is
// registered in the input register, processed by short logic against the controller
// state, and its result is then registered in the result register. One item per
// cycle is sustained while the result channel does not stall; the result register
// alone limits throughput, so a stall on the result channel pushes back to the item channel in the same cycle.
// keyboard_present and mouse_present are written through the cfg port, always
// ready, and select the answers to the keyboard and mouse test commands.
// Depends on ps2kc_pkg and ps2kc_core.
module ps2_keyboard_controller_8042 (
  input  logic       clk,
  input  logic       rst,
  // Item channel
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [2:0] cmd,
  input  logic [7:0] host_byte,
  input  logic [2:0] event_code,
  input  logic [7:0] rx_byte,
  // Result channel
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] read_value,
  output logic       send_valid,
  output logic       send_to_mouse,
  output logic [7:0] send_byte,
  output logic       keyboard_irq_enable,
  output logic       mouse_irq_enable,
  // Configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic       cfg_data
);
  import ps2kc_pkg::*;

  logic    held_valid;
  item_t   held_item;
  logic    advance;
  result_t core_result;
  result_t result_q;
  logic    keyboard_present;
  logic    mouse_present;

  // Move the held beat on when the result register is free or draining
  assign advance    = held_valid && (!result_valid || !result_stall);
  assign item_stall = held_valid && !advance;
  assign cfg_ready  = 1'b1;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!item_stall) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      held_item <= '{cmd: cmd, host_byte: host_byte, event_code: event_code,
                     rx_byte: rx_byte};
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      keyboard_present <= 1'b1;
      mouse_present    <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KBD_PRESENT:   keyboard_present <= cfg_data;
        REG_MOUSE_PRESENT: mouse_present    <= cfg_data;
      endcase
    end
  end

  ps2kc_core u_core (
    .clk              (clk),
    .rst              (rst),
    .fire             (advance),
    .item             (held_item),
    .keyboard_present (keyboard_present),
    .mouse_present    (mouse_present),
    .result           (core_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_q <= core_result;
    end
  end

  assign read_value          = result_q.read_value;
  assign send_valid          = result_q.send_valid;
  assign send_to_mouse       = result_q.send_to_mouse;
  assign send_byte           = result_q.send_byte;
  assign keyboard_irq_enable = result_q.keyboard_irq_enable;
  assign mouse_irq_enable    = result_q.mouse_irq_enable;

  a_advance_fills_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid)
    else $error("processed beat did not reach the result register");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> held_valid && result_valid && result_stall)
    else $error("item channel stalled without a blocked result");

  a_held_kept_on_stall: assert property (@(posedge clk) disable iff (rst)
    item_stall |=> held_valid && $stable(held_item))
    else $error("held beat lost while stalled");

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the dual PS/2 8042-style keyboard controller.
// Drives host accesses and port events with random gaps and stalls, and checks
// every result beat against a cycle-free model of the controller. Needs ps2kc_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ps2kc_pkg::*;

  // Mouse enable/disable commands are accepted but have no effect
  localparam logic [7:0] CMD_AUX_OFF = 8'hA7;
  localparam logic [7:0] CMD_AUX_ON  = 8'hA8;
  localparam int MODE_KBD_INT_BIT = 0;
  localparam int MODE_AUX_INT_BIT = 1;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_stall;
  logic [2:0] cmd = '0;
  logic [7:0] host_byte = '0;
  logic [2:0] event_code = '0;
  logic [7:0] rx_byte = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [7:0] read_value;
  logic       send_valid;
  logic       send_to_mouse;
  logic [7:0] send_byte;
  logic       keyboard_irq_enable;
  logic       mouse_irq_enable;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = 1'b0;
  logic       cfg_data = 1'b0;

  // Controller state as predicted by the testbench
  logic [7:0] shadow_out;
  logic [7:0] shadow_status = '0;
  logic [7:0] shadow_last = '0;
  logic [7:0] shadow_mode = '0;
  logic       shadow_kbd_present = 1'b1;
  logic       shadow_mouse_present = 1'b1;

  item_t   pending_items[$];
  result_t expected_results[$];
  item_t   current_item;
  result_t oldest_result;
  int      mismatches = 0;
  bit      calm = 1'b0;
  bit      out_byte_loaded = 1'b0;

  ps2_keyboard_controller_8042 i_dut (
    .clk                 (clk),
    .rst                 (rst),
    .item_valid          (item_valid),
    .item_stall          (item_stall),
    .cmd                 (cmd),
    .host_byte           (host_byte),
    .event_code          (event_code),
    .rx_byte             (rx_byte),
    .result_valid        (result_valid),
    .result_stall        (result_stall),
    .read_value          (read_value),
    .send_valid          (send_valid),
    .send_to_mouse       (send_to_mouse),
    .send_byte           (send_byte),
    .keyboard_irq_enable (keyboard_irq_enable),
    .mouse_irq_enable    (mouse_irq_enable),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Advance the controller state by one beat and return the result it produces
  function automatic result_t predict_8042(item_t it);
    result_t    r;
    logic [7:0] prior;
    r = '0;
    case (it.cmd)
      SEL_READ_DATA: begin
        r.read_value = shadow_out;
        shadow_status &= ~ST_AUX_OBF;
      end
      SEL_READ_STATUS: begin
        r.read_value = shadow_status;
        shadow_status &= ~(ST_GTO | ST_PERR);
      end
      SEL_WRITE_DATA: begin
        prior = ((shadow_status & ST_CMD) != 0) ? shadow_last : 8'h00;
        shadow_last = it.host_byte;
        shadow_status &= ~ST_CMD;
        if (prior == CC_WRITE_MODE) begin
          shadow_mode = it.host_byte & MODE_MASK;
        end else if (prior == CC_WRITE_AOUT) begin
          shadow_out = it.host_byte;
          shadow_status |= ST_AUX_OBF;
        end else begin
          r.send_valid = 1'b1;
          r.send_to_mouse = (prior == CC_WRITE_AUX);
          r.send_byte = it.host_byte;
          shadow_status |= ST_IBF;
        end
      end
      SEL_WRITE_CMD: begin
        shadow_status |= ST_CMD;
        shadow_last = it.host_byte;
        case (it.host_byte)
          CC_READ_MODE: begin
            shadow_out = shadow_mode;
            shadow_status |= ST_OBF;
          end
          CC_VERSION: begin
            shadow_out = VERSION_BYTE;
            shadow_status |= ST_OBF;
          end
          CC_TEST_AUX: begin
            shadow_out = shadow_mouse_present ? TEST_PASS : TEST_FAIL;
            shadow_status |= ST_OBF;
          end
          CC_SELF_TEST: begin
            shadow_out = SELF_OK;
            shadow_status |= ST_OBF | ST_SELFTEST;
          end
          CC_TEST_KBD: begin
            shadow_out = shadow_kbd_present ? TEST_PASS : TEST_FAIL;
            shadow_status |= ST_OBF;
          end
          CC_KBD_OFF: shadow_mode |= MODE_DIS_KBD;
          CC_KBD_ON:  shadow_mode &= ~MODE_DIS_KBD;
          default: ;
        endcase
        shadow_status &= ~ST_IBF;
      end
      SEL_KBD_EVENT: begin
        case (it.event_code)
          EV_SENT:     shadow_status &= ~ST_IBF;
          EV_RECEIVED: begin
            shadow_out = it.rx_byte;
            shadow_status |= ST_OBF;
          end
          EV_RX_ERROR, EV_OVERFLOW: shadow_status |= ST_PERR;
          EV_NO_ACK, EV_TIMEOUT:    shadow_status |= ST_GTO;
          default: ;
        endcase
      end
      SEL_MOUSE_EVENT: begin
        // Mouse errors leave the status alone
        case (it.event_code)
          EV_SENT:     shadow_status &= ~ST_IBF;
          EV_RECEIVED: begin
            shadow_out = it.rx_byte;
            shadow_status |= ST_AUX_OBF;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    r.keyboard_irq_enable = shadow_mode[MODE_KBD_INT_BIT];
    r.mouse_irq_enable = shadow_mode[MODE_AUX_INT_BIT];
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endfunction

  // Queue one beat; note when the output byte becomes safe to read
  function automatic void add_item(logic [2:0] sel, logic [7:0] hb, logic [2:0] ev,
                                   logic [7:0] rx);
    item_t it;
    it.cmd = sel;
    it.host_byte = hb;
    it.event_code = ev;
    it.rx_byte = rx;
    pending_items.push_back(it);
    if (sel == SEL_WRITE_CMD && (hb == CC_READ_MODE || hb == CC_VERSION ||
        hb == CC_TEST_AUX || hb == CC_SELF_TEST || hb == CC_TEST_KBD))
      out_byte_loaded = 1'b1;
    if ((sel == SEL_KBD_EVENT || sel == SEL_MOUSE_EVENT) && ev == EV_RECEIVED)
      out_byte_loaded = 1'b1;
  endfunction

  function automatic logic [7:0] known_command(int k);
    case (k)
      0:       return CC_READ_MODE;
      1:       return CC_WRITE_MODE;
      2:       return CC_VERSION;
      3:       return CMD_AUX_OFF;
      4:       return CMD_AUX_ON;
      5:       return CC_TEST_AUX;
      6:       return CC_SELF_TEST;
      7:       return CC_TEST_KBD;
      8:       return CC_KBD_OFF;
      9:       return CC_KBD_ON;
      10:      return CC_WRITE_AOUT;
      default: return CC_WRITE_AUX;
    endcase
  endfunction

  // Extremes, every command but the mouse enable, and some events of both ports
  task automatic queue_directed();
    add_item(SEL_WRITE_CMD, CC_SELF_TEST, EV_SENT, 8'h00);
    add_item(SEL_READ_DATA, 8'hFF, 3'd7, 8'hFF);
    add_item(SEL_WRITE_CMD, CC_WRITE_MODE, EV_SENT, 8'h00);
    add_item(SEL_WRITE_DATA, 8'hFF, EV_SENT, 8'h00);
    add_item(SEL_WRITE_CMD, CC_READ_MODE, EV_SENT, 8'h00);
    add_item(SEL_READ_DATA, 8'h00, EV_SENT, 8'h00);
    add_item(SEL_WRITE_CMD, CC_VERSION, EV_SENT, 8'h00);
    add_item(SEL_WRITE_CMD, CC_TEST_AUX, EV_SENT, 8'h00);
    add_item(SEL_WRITE_CMD, CC_TEST_KBD, EV_SENT, 8'h00);
    add_item(SEL_WRITE_CMD, CC_KBD_OFF, EV_SENT, 8'h00);
    add_item(SEL_WRITE_CMD, CC_KBD_ON, EV_SENT, 8'h00);
    add_item(SEL_WRITE_CMD, CMD_AUX_OFF, EV_SENT, 8'h00);
    add_item(SEL_WRITE_CMD, CC_WRITE_AOUT, EV_SENT, 8'h00);
    add_item(SEL_WRITE_DATA, 8'h5A, EV_SENT, 8'h00);
    add_item(SEL_READ_DATA, 8'h00, EV_SENT, 8'h00);
    add_item(SEL_WRITE_CMD, CC_WRITE_AUX, EV_SENT, 8'h00);
    add_item(SEL_WRITE_DATA, 8'h00, EV_SENT, 8'h00);
    add_item(SEL_WRITE_DATA, 8'hFF, EV_SENT, 8'h00);
    add_item(SEL_KBD_EVENT, 8'h00, EV_RECEIVED, 8'hFF);
    add_item(SEL_KBD_EVENT, 8'h00, EV_OVERFLOW, 8'h00);
    add_item(SEL_KBD_EVENT, 8'h00, EV_TIMEOUT, 8'h00);
    add_item(SEL_READ_STATUS, 8'h00, EV_SENT, 8'h00);
    add_item(SEL_MOUSE_EVENT, 8'h00, EV_RECEIVED, 8'h00);
    add_item(SEL_MOUSE_EVENT, 8'h00, EV_NO_ACK, 8'h00);
    add_item(SEL_KBD_EVENT, 8'h00, EV_SENT, 8'h00);
    add_item(SEL_WRITE_CMD, 8'hFF, EV_SENT, 8'h00);
    add_item(3'd7, 8'hFF, 3'd6, 8'hFF);
  endtask

  // Mostly well-formed command sequences with random content, plus noise
  task automatic queue_random_items(int count);
    int         n;
    int         pick;
    logic [7:0] code;
    logic [2:0] ev;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(99);
      if (pick < 28) begin
        code = known_command($urandom_range(11));
        add_item(SEL_WRITE_CMD, code, 3'($urandom), 8'($urandom));
        n++;
        if ((code == CC_WRITE_MODE || code == CC_WRITE_AOUT || code == CC_WRITE_AUX) &&
            $urandom_range(99) < 85) begin
          add_item(SEL_WRITE_DATA, 8'($urandom), 3'($urandom), 8'($urandom));
          n++;
        end
      end else if (pick < 40) begin
        add_item(SEL_WRITE_DATA, 8'($urandom), 3'($urandom), 8'($urandom));
        n++;
      end else if (pick < 47) begin
        add_item(SEL_WRITE_CMD, 8'($urandom), 3'($urandom), 8'($urandom));
        n++;
      end else if (pick < 62) begin
        add_item(SEL_READ_STATUS, 8'($urandom), 3'($urandom), 8'($urandom));
        n++;
      end else if (pick < 75) begin
        // Hold reads off until the output byte has been loaded once
        if (out_byte_loaded) begin
          add_item(SEL_READ_DATA, 8'($urandom), 3'($urandom), 8'($urandom));
          n++;
        end
      end else if (pick < 97) begin
        ev = ($urandom_range(99) < 90) ? 3'($urandom_range(5)) : 3'($urandom_range(7, 6));
        add_item($urandom_range(1) ? SEL_MOUSE_EVENT : SEL_KBD_EVENT, 8'($urandom), ev,
                 8'($urandom));
        n++;
      end else begin
        add_item(3'($urandom_range(7, 6)), 8'($urandom), 3'($urandom), 8'($urandom));
      end
    end
  endtask

  task automatic write_register(cfg_reg_t idx, logic val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_KBD_PRESENT)
      shadow_kbd_present = val;
    else
      shadow_mouse_present = val;
  endtask

  // Wait until every queued beat has gone through and its result came back
  task automatic drain();
    do @(negedge clk);
    while (pending_items.size() != 0 || item_valid || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Item driver: load the next beat when the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || !item_stall) begin
      if (item_valid)
        expected_results.push_back(predict_8042(current_item));
      if (pending_items.size() != 0 && (calm || $urandom_range(99) >= 11)) begin
        current_item = pending_items.pop_front();
        item_valid <= 1'b1;
        cmd <= current_item.cmd;
        host_byte <= current_item.host_byte;
        event_code <= current_item.event_code;
        rx_byte <= current_item.rx_byte;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= !calm && ($urandom_range(99) < 11);
    end
  end

  // Result monitor: compare each beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no prediction pending");
        mismatches++;
      end else begin
        oldest_result = expected_results.pop_front();
        check_field("read_value", oldest_result.read_value, read_value);
        check_field("send_valid", oldest_result.send_valid, send_valid);
        check_field("send_to_mouse", oldest_result.send_to_mouse, send_to_mouse);
        check_field("send_byte", oldest_result.send_byte, send_byte);
        check_field("keyboard_irq_enable", oldest_result.keyboard_irq_enable,
                    keyboard_irq_enable);
        check_field("mouse_irq_enable", oldest_result.mouse_irq_enable,
                    mouse_irq_enable);
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    write_register(REG_KBD_PRESENT, 1'b1);
    write_register(REG_MOUSE_PRESENT, 1'b1);
    queue_directed();
    drain();

    write_register(REG_KBD_PRESENT, 1'b0);
    write_register(REG_MOUSE_PRESENT, 1'b1);
    queue_random_items(460);
    drain();

    // No idling on either side through this phase
    calm = 1'b1;
    write_register(REG_KBD_PRESENT, 1'b1);
    write_register(REG_MOUSE_PRESENT, 1'b0);
    queue_random_items(460);
    drain();
    calm = 1'b0;

    write_register(REG_KBD_PRESENT, 1'b0);
    write_register(REG_MOUSE_PRESENT, 1'b0);
    queue_random_items(460);
    drain();

    write_register(REG_KBD_PRESENT, 1'b1);
    write_register(REG_MOUSE_PRESENT, 1'b1);
    queue_random_items(460);
    drain();

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("ps2_keyboard_controller_8042 verification clean");
    end else begin
      $display("ps2_keyboard_controller_8042 verification failed");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #2000000;
    $display("ps2_keyboard_controller_8042 verification failed");
    $finish;
  end

endmodule
